// ===== rtl/rgb2hsv_pkg.sv =====
// Shared types, constants and the divider step for the RGB to HSV converter.
// No dependencies; every other file in rtl/ uses it by scoped names.
`timescale 1ns / 1ps
package rgb2hsv_pkg;

  localparam int CH_W             = 8;
  localparam int HUE_W            = 9;
  localparam int PCT_W            = 15;
  localparam int QUO_W            = 15;
  localparam int DEN_W            = 8;
  localparam int NUM_W            = DEN_W + QUO_W;
  localparam int CHANNEL_FULL     = 255;
  localparam int PERCENT_Q8       = 25600;
  localparam int HUE_SECTOR_DEG   = 60;
  localparam int HUE_GREEN_OFFSET = 120;
  localparam int HUE_BLUE_OFFSET  = 240;
  localparam int HUE_FULL_TURN    = 360;
  localparam int QUEUE_DEPTH      = 2;

  // value = max * 25600 / 255 as a reciprocal multiply, exact for every byte
  localparam int VAL_SHIFT  = 16;
  localparam int VAL_RECIP  = (PERCENT_Q8 * (1 << VAL_SHIFT) + CHANNEL_FULL - 1)
                              / CHANNEL_FULL;
  localparam int VAL_PROD_W = 31;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_degrees;
    logic [PCT_W-1:0] saturation_q8;
    logic [PCT_W-1:0] value_q8;
  } hsv_t;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  // one restoring-division lane: dividend bits still to go, divisor,
  // partial remainder and quotient so far
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t            hue;
    lane_t            sat;
    logic [PCT_W-1:0] val;
    logic [HUE_W-1:0] base;
    logic             neg;
    logic             gray;
  } job_t;

  // retire one quotient bit, then shift the next dividend bit into place
  function automatic lane_t div_step(lane_t l);
    logic [DEN_W:0] part;
    logic           ge;
    lane_t          res;
    part     = {l.rem, l.num[QUO_W-1]};
    ge       = part >= {1'b0, l.den};
    res      = l;
    res.rem  = ge ? DEN_W'(part - {1'b0, l.den}) : part[DEN_W-1:0];
    res.quo  = {l.quo[QUO_W-2:0], ge};
    res.num  = {l.num[NUM_W-2:0], 1'b0};
    return res;
  endfunction

endpackage

// ===== rtl/rgb_to_hsv.sv =====
// RGB to HSV converter, top level: front end, job queue, divider pipeline.
// Depends on rgb2hsv_pkg, rgb2hsv_front, rgb2hsv_queue, rgb2hsv_back.
//
// Usage:
//   Drive a pixel on in_pixel and raise start; the item is taken at a rising
//   edge where start is high and busy is low. One item per clock is taken
//   back to back, so a camera or display stream runs at full pixel rate.
//   Each item yields one result on out_result, marked by out_valid for
//   exactly one cycle; the receiver cannot stall, so there is no ready.
//   The accepting edge loads the front end register; the item then passes
//   the job queue, fifteen divider stages (one quotient bit each, set by
//   the 15-bit saturation quotient) and the result register, whose load
//   raises out_valid. Throughput is one item per cycle; busy only rises if
//   the queue fills, which the divider pipeline never allows since it
//   drains the queue every cycle.
//   Reset (rst_n low, synchronous) empties the front end, queue and
//   pipeline; items in flight are dropped and no result appears for them.
`timescale 1ns / 1ps
module rgb_to_hsv #(
  parameter int QUEUE_DEPTH = rgb2hsv_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rgb2hsv_pkg::pixel_t in_pixel,
  output logic                busy,
  output logic                out_valid,
  output rgb2hsv_pkg::hsv_t   out_result
);

  localparam int LATENCY = rgb2hsv_pkg::QUO_W + 3;

  logic              q_full, job_valid, q_pop;
  rgb2hsv_pkg::job_t job, head;

  rgb2hsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_pixel  (in_pixel),
    .busy      (busy),
    .q_full    (q_full),
    .job_valid (job_valid),
    .job       (job)
  );

  rgb2hsv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head)
  );

  rgb2hsv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_pop),
    .in_job     (head),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted item");

  a_gray_hue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.saturation_q8 == '0) |-> out_result.hue_degrees == '0)
    else $error("zero saturation with nonzero hue");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.hue_degrees < 9'(rgb2hsv_pkg::HUE_FULL_TURN)
      && out_result.saturation_q8 <= 15'(rgb2hsv_pkg::PERCENT_Q8)))
    else $error("result field out of range");

endmodule

// ===== rtl/rgb2hsv_front.sv =====
// Front end: takes pixel items, finds max/min and hue sector, and builds
// the hue and saturation division jobs and the value. Depends on rgb2hsv_pkg.
`timescale 1ns / 1ps
module rgb2hsv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rgb2hsv_pkg::pixel_t in_pixel,
  output logic                busy,
  input  logic                q_full,
  output logic                job_valid,
  output rgb2hsv_pkg::job_t   job
);

  localparam int CH_W       = rgb2hsv_pkg::CH_W;
  localparam int NUM_W      = rgb2hsv_pkg::NUM_W;
  localparam int QUO_W      = rgb2hsv_pkg::QUO_W;
  localparam int HUE_W      = rgb2hsv_pkg::HUE_W;
  localparam int PCT_W      = rgb2hsv_pkg::PCT_W;
  localparam int VAL_PROD_W = rgb2hsv_pkg::VAL_PROD_W;

  logic                valid_r, valid_nxt;
  rgb2hsv_pkg::job_t   job_r, job_nxt;
  rgb2hsv_pkg::sector_t sector;
  logic [CH_W-1:0]     mx, mn, d, op_a, op_b, mag;
  logic                neg, accept, push;
  logic [NUM_W-1:0]    hue_num, sat_num;
  logic [VAL_PROD_W-1:0] val_prod;

  assign busy   = valid_r && q_full;
  assign accept = start && !busy;
  assign push   = valid_r && !q_full;

  always_comb begin
    if (in_pixel.red >= in_pixel.green && in_pixel.red >= in_pixel.blue) begin
      sector = rgb2hsv_pkg::SECTOR_RED;
    end else if (in_pixel.green >= in_pixel.blue) begin
      sector = rgb2hsv_pkg::SECTOR_GREEN;
    end else begin
      sector = rgb2hsv_pkg::SECTOR_BLUE;
    end

    mn = in_pixel.red;
    if (in_pixel.green < mn) mn = in_pixel.green;
    if (in_pixel.blue < mn) mn = in_pixel.blue;

    case (sector)
      rgb2hsv_pkg::SECTOR_RED: begin
        mx   = in_pixel.red;
        op_a = in_pixel.green;
        op_b = in_pixel.blue;
      end
      rgb2hsv_pkg::SECTOR_GREEN: begin
        mx   = in_pixel.green;
        op_a = in_pixel.blue;
        op_b = in_pixel.red;
      end
      default: begin
        mx   = in_pixel.blue;
        op_a = in_pixel.red;
        op_b = in_pixel.green;
      end
    endcase

    d   = mx - mn;
    neg = op_a < op_b;
    mag = neg ? op_b - op_a : op_a - op_b;

    hue_num  = NUM_W'(mag) * NUM_W'(rgb2hsv_pkg::HUE_SECTOR_DEG);
    sat_num  = NUM_W'(d) * NUM_W'(rgb2hsv_pkg::PERCENT_Q8);
    val_prod = VAL_PROD_W'(mx) * VAL_PROD_W'(rgb2hsv_pkg::VAL_RECIP);

    job_nxt.hue.num = hue_num;
    job_nxt.hue.den = d;
    job_nxt.hue.rem = hue_num[NUM_W-1:QUO_W];
    job_nxt.hue.quo = '0;
    job_nxt.sat.num = sat_num;
    job_nxt.sat.den = mx;
    job_nxt.sat.rem = sat_num[NUM_W-1:QUO_W];
    job_nxt.sat.quo = '0;
    job_nxt.val     = val_prod[rgb2hsv_pkg::VAL_SHIFT +: PCT_W];
    job_nxt.neg     = neg;
    job_nxt.gray    = d == '0;

    case (sector)
      rgb2hsv_pkg::SECTOR_RED:
        job_nxt.base = neg ? HUE_W'(rgb2hsv_pkg::HUE_FULL_TURN) : '0;
      rgb2hsv_pkg::SECTOR_GREEN:
        job_nxt.base = HUE_W'(rgb2hsv_pkg::HUE_GREEN_OFFSET);
      default:
        job_nxt.base = HUE_W'(rgb2hsv_pkg::HUE_BLUE_OFFSET);
    endcase

    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = push;
  assign job       = job_r;

endmodule

// ===== rtl/rgb2hsv_queue.sv =====
// Short job queue between front end and divider pipeline; drains one job
// per cycle whenever it holds any. Depends on rgb2hsv_pkg.
`timescale 1ns / 1ps
module rgb2hsv_queue #(
  parameter int DEPTH = rgb2hsv_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rgb2hsv_pkg::job_t push_job,
  output logic              full,
  output logic              pop,
  output rgb2hsv_pkg::job_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rgb2hsv_pkg::job_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full = count_r == CNT_W'(DEPTH);
  assign pop  = count_r != '0;
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/rgb2hsv_back.sv =====
// Back end: restoring-division pipeline, one quotient bit per stage for
// hue and saturation, then the hue fix-up and result register.
// Depends on rgb2hsv_pkg.
`timescale 1ns / 1ps
module rgb2hsv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rgb2hsv_pkg::job_t  in_job,
  output logic               out_valid,
  output rgb2hsv_pkg::hsv_t  out_result
);

  localparam int STAGES = rgb2hsv_pkg::QUO_W;
  localparam int HUE_W  = rgb2hsv_pkg::HUE_W;
  localparam int PCT_W  = rgb2hsv_pkg::PCT_W;

  logic              stage_valid_r [STAGES];
  rgb2hsv_pkg::job_t stage_r [STAGES];
  logic              out_valid_r;
  rgb2hsv_pkg::hsv_t out_result_r, out_result_nxt;
  rgb2hsv_pkg::job_t last;
  logic [HUE_W-1:0]  q9, hue_raw;

  function automatic rgb2hsv_pkg::job_t job_step(rgb2hsv_pkg::job_t j);
    rgb2hsv_pkg::job_t res;
    res     = j;
    res.hue = rgb2hsv_pkg::div_step(j.hue);
    res.sat = rgb2hsv_pkg::div_step(j.sat);
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        stage_valid_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      stage_valid_r[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        stage_valid_r[i] <= stage_valid_r[i-1];
      end
      out_valid_r <= stage_valid_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    stage_r[0] <= job_step(in_job);
    for (int i = 1; i < STAGES; i++) begin
      stage_r[i] <= job_step(stage_r[i-1]);
    end
    out_result_r <= out_result_nxt;
  end

  // a negative zero in the red sector lands on a full turn: fold it to 0
  always_comb begin
    last    = stage_r[STAGES-1];
    q9      = last.hue.quo[HUE_W-1:0];
    hue_raw = last.neg ? last.base - q9 : last.base + q9;
    if (last.gray || hue_raw == HUE_W'(rgb2hsv_pkg::HUE_FULL_TURN)) begin
      out_result_nxt.hue_degrees = '0;
    end else begin
      out_result_nxt.hue_degrees = hue_raw;
    end
    out_result_nxt.saturation_q8 = last.gray ? '0 : last.sat.quo[PCT_W-1:0];
    out_result_nxt.value_q8      = last.val;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule
